### rtl/core/accio_pkg.sv
// Shared types and constants for the accumulator processor with character I/O.
package accio_pkg;

   typedef enum logic [0:0] {
      CMD_LOAD = 1'b0,
      CMD_RUN  = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      OP_LOAD  = 3'd0,
      OP_STORE = 3'd1,
      OP_ADD   = 3'd2,
      OP_SUB   = 3'd3,
      OP_JMP   = 3'd4,
      OP_JNEG  = 3'd5,
      OP_JPOS  = 3'd6,
      OP_JZERO = 3'd7
   } op_type;

   typedef struct packed {
      logic load_en;
      logic in_taken;
      logic out_emit;
      logic store_en;
   } mem_ctl_type;

   localparam logic [7:0] NEWLINE_CHAR = 8'd10;
   localparam logic [7:0] BYTE_MASK    = 8'hFF;

endpackage

### rtl/core/accio_regfile.sv
// Word store with reset contents and the load, input, output and store write ports.
module accio_regfile import accio_pkg::*; #(
   parameter int DATA_WIDTH = 8,
   parameter int IN_CELL    = 30,
   parameter int OUT_CELL   = 31
) (
   input  logic                    clock,
   input  logic                    reset,
   input  mem_ctl_type             wr_ctl,
   input  logic [DATA_WIDTH-4:0]   load_addr,
   input  logic [DATA_WIDTH-1:0]   load_word,
   input  logic [DATA_WIDTH-1:0]   in_word,
   input  logic [DATA_WIDTH-1:0]   out_word,
   input  logic [DATA_WIDTH-4:0]   store_addr,
   input  logic [DATA_WIDTH-1:0]   store_word,
   input  logic [DATA_WIDTH-4:0]   pc_addr,
   input  logic [DATA_WIDTH-4:0]   ea_addr,
   output logic [DATA_WIDTH-1:0]   pc_data,
   output logic [DATA_WIDTH-1:0]   ea_data,
   output logic [DATA_WIDTH-1:0]   icell_data,
   output logic [DATA_WIDTH-1:0]   ocell_data
);

   localparam int ADDR_BITS = DATA_WIDTH - 3;
   localparam int DEPTH     = 1 << ADDR_BITS;
   localparam logic [ADDR_BITS-1:0] ICELL = ADDR_BITS'(IN_CELL);
   localparam logic [ADDR_BITS-1:0] OCELL = ADDR_BITS'(OUT_CELL);

   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];

   // The store of a run item takes precedence over the output cell, which takes
   // precedence over the input cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            if (ADDR_BITS'(i) == ICELL) begin
               mem_ff[i] <= DATA_WIDTH'(NEWLINE_CHAR);
            end else begin
               mem_ff[i] <= '0;
            end
         end
      end else if (wr_ctl.load_en) begin
         mem_ff[load_addr] <= load_word;
      end else begin
         for (int i = 0; i < DEPTH; i++) begin
            if (wr_ctl.store_en && store_addr == ADDR_BITS'(i)) begin
               mem_ff[i] <= store_word;
            end else if (wr_ctl.out_emit && OCELL == ADDR_BITS'(i)) begin
               mem_ff[i] <= out_word;
            end else if (wr_ctl.in_taken && ICELL == ADDR_BITS'(i)) begin
               mem_ff[i] <= in_word;
            end
         end
      end
   end

   assign pc_data    = mem_ff[pc_addr];
   assign ea_data    = mem_ff[ea_addr];
   assign icell_data = mem_ff[ICELL];
   assign ocell_data = mem_ff[OCELL];

endmodule

### rtl/core/accio_exec.sv
// One machine cycle: character I/O on the mapped cells, fetch and execute.
module accio_exec import accio_pkg::*; #(
   parameter int DATA_WIDTH = 8,
   parameter int IN_CELL    = 30,
   parameter int OUT_CELL   = 31
) (
   input  logic                    load,
   input  logic                    run,
   input  logic [7:0]              in_char,
   input  logic [DATA_WIDTH-1:0]   acc,
   input  logic [DATA_WIDTH-1:0]   pc,
   input  logic [DATA_WIDTH-1:0]   icell_data,
   input  logic [DATA_WIDTH-1:0]   ocell_data,
   input  logic [DATA_WIDTH-1:0]   pc_data,
   input  logic [DATA_WIDTH-1:0]   ea_data,
   output mem_ctl_type             wr_ctl,
   output logic [DATA_WIDTH-1:0]   in_word,
   output logic [DATA_WIDTH-1:0]   out_word,
   output logic [DATA_WIDTH-4:0]   pc_addr,
   output logic [DATA_WIDTH-4:0]   ea_addr,
   output logic [DATA_WIDTH-1:0]   acc_next,
   output logic [DATA_WIDTH-1:0]   pc_next,
   output logic [7:0]              out_char
);

   localparam int ADDR_BITS = DATA_WIDTH - 3;
   localparam logic [ADDR_BITS-1:0] ICELL = ADDR_BITS'(IN_CELL);
   localparam logic [ADDR_BITS-1:0] OCELL = ADDR_BITS'(OUT_CELL);
   localparam logic [DATA_WIDTH-1:0] HIGH_MASK = ~DATA_WIDTH'(BYTE_MASK);

   logic                  taken;
   logic                  emit;
   logic [DATA_WIDTH-1:0] out_pre;
   logic [DATA_WIDTH-1:0] instr;
   logic [DATA_WIDTH-1:0] operand;
   op_type                op;
   logic                  acc_neg;
   logic                  acc_zero;
   logic                  jump;

   // The input step runs before the output step, so a shared cell sees the new character.
   always_comb begin
      taken    = run && (icell_data[7:0] == 8'd0);
      in_word  = (icell_data & HIGH_MASK) | DATA_WIDTH'(in_char);
      out_pre  = (ICELL == OCELL && taken) ? in_word : ocell_data;
      emit     = run && (out_pre[7:0] != 8'd0);
      out_word = out_pre & HIGH_MASK;
      out_char = emit ? out_pre[7:0] : 8'd0;
   end

   // Fetch and operand reads see the cells as left by the I/O steps.
   always_comb begin
      pc_addr = pc[ADDR_BITS-1:0];
      if (emit && pc_addr == OCELL) begin
         instr = out_word;
      end else if (taken && pc_addr == ICELL) begin
         instr = in_word;
      end else begin
         instr = pc_data;
      end
      ea_addr = instr[ADDR_BITS-1:0];
      if (emit && ea_addr == OCELL) begin
         operand = out_word;
      end else if (taken && ea_addr == ICELL) begin
         operand = in_word;
      end else begin
         operand = ea_data;
      end
      op = op_type'(instr[DATA_WIDTH-1 -: 3]);
   end

   always_comb begin
      acc_neg  = acc[DATA_WIDTH-1];
      acc_zero = (acc == '0);
      acc_next = acc;
      jump     = 1'b0;
      unique case (op)
         OP_LOAD:  acc_next = operand;
         OP_STORE: acc_next = acc;
         OP_ADD:   acc_next = acc + operand;
         OP_SUB:   acc_next = acc - operand;
         OP_JMP:   jump = 1'b1;
         OP_JNEG:  jump = acc_neg;
         OP_JPOS:  jump = !acc_neg && !acc_zero;
         OP_JZERO: jump = acc_zero;
         default:  jump = 1'b0;
      endcase
      if (!run) begin
         acc_next = acc;
         pc_next  = pc;
      end else if (jump) begin
         pc_next = instr;
      end else begin
         pc_next = pc + DATA_WIDTH'(1);
      end
      wr_ctl.load_en  = load;
      wr_ctl.in_taken = taken;
      wr_ctl.out_emit = emit;
      wr_ctl.store_en = run && (op == OP_STORE);
   end

endmodule

### rtl/core/accumulator_cpu_with_char_io_top.sv
// Top level of the accumulator processor with memory-mapped character I/O.
// An item passes the request register, then the response register drives the rsp_ ports.
// One item per cycle while rsp_stall is low; each machine cycle is one register stage.
// The word store is a register file read and written in the same cycle as the execute step.
// Reset is synchronous and active high: accumulator and program counter go to zero, every
// memory word to zero except the input cell, which holds newline.
module accumulator_cpu_with_char_io_top import accio_pkg::*; #(
   parameter int DATA_WIDTH = 8,
   parameter int IN_CELL    = 30,
   parameter int OUT_CELL   = 31
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_cmd,
   input  logic [4:0] req_load_addr,
   input  logic [7:0] req_load_word,
   input  logic [7:0] req_in_char,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_out_valid,
   output logic [7:0] rsp_out_char,
   output logic       rsp_in_taken,
   output logic [7:0] rsp_pc_now,
   output logic [7:0] rsp_acc_now
);

   localparam int ADDR_BITS = DATA_WIDTH - 3;

   logic                  s1_valid_ff;
   logic                  s1_cmd_ff;
   logic [4:0]            s1_load_addr_ff;
   logic [7:0]            s1_load_word_ff;
   logic [7:0]            s1_in_char_ff;
   logic [DATA_WIDTH-1:0] acc_ff;
   logic [DATA_WIDTH-1:0] pc_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_out_valid_ff;
   logic [7:0]            rsp_out_char_ff;
   logic                  rsp_in_taken_ff;
   logic [7:0]            rsp_pc_now_ff;
   logic [7:0]            rsp_acc_now_ff;

   logic                  out_free;
   logic                  fire;
   logic                  run;
   logic                  load;
   mem_ctl_type           wr_ctl;
   logic [DATA_WIDTH-1:0] in_word;
   logic [DATA_WIDTH-1:0] out_word;
   logic [ADDR_BITS-1:0]  pc_addr;
   logic [ADDR_BITS-1:0]  ea_addr;
   logic [DATA_WIDTH-1:0] pc_data;
   logic [DATA_WIDTH-1:0] ea_data;
   logic [DATA_WIDTH-1:0] icell_data;
   logic [DATA_WIDTH-1:0] ocell_data;
   logic [DATA_WIDTH-1:0] acc_next;
   logic [DATA_WIDTH-1:0] pc_next;
   logic [7:0]            out_char;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fire      = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign run       = fire && (s1_cmd_ff == CMD_RUN);
   assign load      = fire && (s1_cmd_ff == CMD_LOAD);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_cmd_ff       <= req_cmd;
         s1_load_addr_ff <= req_load_addr;
         s1_load_word_ff <= req_load_word;
         s1_in_char_ff   <= req_in_char;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         pc_ff  <= '0;
      end else if (fire) begin
         acc_ff <= acc_next;
         pc_ff  <= pc_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= fire;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_out_valid_ff <= wr_ctl.out_emit;
         rsp_out_char_ff  <= out_char;
         rsp_in_taken_ff  <= wr_ctl.in_taken;
         rsp_pc_now_ff    <= pc_next[7:0];
         rsp_acc_now_ff   <= acc_next[7:0];
      end
   end

   accio_exec #(
      .DATA_WIDTH (DATA_WIDTH),
      .IN_CELL    (IN_CELL),
      .OUT_CELL   (OUT_CELL)
   ) u_exec (
      .load       (load),
      .run        (run),
      .in_char    (s1_in_char_ff),
      .acc        (acc_ff),
      .pc         (pc_ff),
      .icell_data (icell_data),
      .ocell_data (ocell_data),
      .pc_data    (pc_data),
      .ea_data    (ea_data),
      .wr_ctl     (wr_ctl),
      .in_word    (in_word),
      .out_word   (out_word),
      .pc_addr    (pc_addr),
      .ea_addr    (ea_addr),
      .acc_next   (acc_next),
      .pc_next    (pc_next),
      .out_char   (out_char)
   );

   accio_regfile #(
      .DATA_WIDTH (DATA_WIDTH),
      .IN_CELL    (IN_CELL),
      .OUT_CELL   (OUT_CELL)
   ) u_regfile (
      .clock      (clock),
      .reset      (reset),
      .wr_ctl     (wr_ctl),
      .load_addr  (ADDR_BITS'(s1_load_addr_ff)),
      .load_word  (DATA_WIDTH'(s1_load_word_ff)),
      .in_word    (in_word),
      .out_word   (out_word),
      .store_addr (ea_addr),
      .store_word (acc_ff),
      .pc_addr    (pc_addr),
      .ea_addr    (ea_addr),
      .pc_data    (pc_data),
      .ea_data    (ea_data),
      .icell_data (icell_data),
      .ocell_data (ocell_data)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_valid = rsp_out_valid_ff;
   assign rsp_out_char  = rsp_out_char_ff;
   assign rsp_in_taken  = rsp_in_taken_ff;
   assign rsp_pc_now    = rsp_pc_now_ff;
   assign rsp_acc_now   = rsp_acc_now_ff;

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the accumulator processor with character I/O.
module tb_top;
   import accio_pkg::*;

   localparam int TOTAL_ITEMS  = 850;
   localparam int HANG_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 8;
   localparam logic [4:0] INPUT_CELL  = 5'd30;
   localparam logic [4:0] OUTPUT_CELL = 5'd31;

   typedef struct {
      cmd_type    cmd;
      logic [4:0] load_addr;
      logic [7:0] load_word;
      logic [7:0] in_char;
      bit         drain_first;
   } cpu_item_t;

   typedef struct packed {
      logic       out_valid;
      logic [7:0] out_char;
      logic       in_taken;
      logic [7:0] pc_now;
      logic [7:0] acc_now;
   } cycle_report_t;

   logic       clock         = 1'b0;
   logic       reset         = 1'b1;
   logic       req_valid     = 1'b0;
   logic       req_cmd       = CMD_LOAD;
   logic [4:0] req_load_addr = '0;
   logic [7:0] req_load_word = '0;
   logic [7:0] req_in_char   = '0;
   logic       rsp_stall     = 1'b0;
   logic       req_stall;
   logic       rsp_valid;
   logic       rsp_out_valid;
   logic [7:0] rsp_out_char;
   logic       rsp_in_taken;
   logic [7:0] rsp_pc_now;
   logic [7:0] rsp_acc_now;

   cpu_item_t     pending_items[$];
   cycle_report_t expected_reports[$];
   cpu_item_t     active_item;

   logic [7:0] cpu_mem [0:31];
   logic [7:0] cpu_acc;
   logic [7:0] cpu_pc;

   int total_items  = TOTAL_ITEMS;
   int n_items      = 0;
   int n_runs       = 0;
   int n_checked    = 0;
   int n_emitted    = 0;
   int n_taken      = 0;
   int n_errors     = 0;
   int stuck_cycles = 0;
   int idle_phase   = 0;

   accumulator_cpu_with_char_io_top uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cmd       (req_cmd),
      .req_load_addr (req_load_addr),
      .req_load_word (req_load_word),
      .req_in_char   (req_in_char),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_valid (rsp_out_valid),
      .rsp_out_char  (rsp_out_char),
      .rsp_in_taken  (rsp_in_taken),
      .rsp_pc_now    (rsp_pc_now),
      .rsp_acc_now   (rsp_acc_now)
   );

   always #6 clock = ~clock;

   function automatic cycle_report_t execute_item(input cpu_item_t it);
      cycle_report_t rep;
      logic [7:0]    instr;
      logic [7:0]    operand;
      logic [4:0]    ea;
      logic          acc_neg;
      logic          acc_zero;
      op_type        op;
      rep = '0;
      if (it.cmd == CMD_LOAD) begin
         cpu_mem[it.load_addr] = it.load_word;
      end else begin
         if (cpu_mem[INPUT_CELL] == 8'h00) begin
            cpu_mem[INPUT_CELL] = it.in_char;
            rep.in_taken = 1'b1;
         end
         if (cpu_mem[OUTPUT_CELL] != 8'h00) begin
            rep.out_valid = 1'b1;
            rep.out_char = cpu_mem[OUTPUT_CELL];
            cpu_mem[OUTPUT_CELL] = 8'h00;
         end
         instr = cpu_mem[cpu_pc[4:0]];
         cpu_pc = cpu_pc + 8'd1;
         op = op_type'(instr[7:5]);
         ea = instr[4:0];
         acc_neg = cpu_acc[7];
         acc_zero = (cpu_acc == 8'h00);
         operand = cpu_mem[ea];
         case (op)
            OP_LOAD:  cpu_acc = operand;
            OP_STORE: cpu_mem[ea] = cpu_acc;
            OP_ADD:   cpu_acc = cpu_acc + operand;
            OP_SUB:   cpu_acc = cpu_acc - operand;
            OP_JMP:   cpu_pc = instr;
            OP_JNEG:  if (acc_neg) cpu_pc = instr;
            OP_JPOS:  if (!acc_neg && !acc_zero) cpu_pc = instr;
            OP_JZERO: if (acc_zero) cpu_pc = instr;
         endcase
      end
      rep.pc_now = cpu_pc;
      rep.acc_now = cpu_acc;
      return rep;
   endfunction

   task automatic queue_item(input cmd_type cmd, input logic [4:0] addr, input logic [7:0] word,
                             input logic [7:0] ch, input bit drain = 1'b0);
      cpu_item_t it;
      it.cmd = cmd;
      it.load_addr = addr;
      it.load_word = word;
      it.in_char = ch;
      it.drain_first = drain;
      pending_items.push_back(it);
   endtask

   task automatic check_field(input string field, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 0x%02h, actual 0x%02h", $time, field, want, got);
         n_errors++;
      end
   endtask

   always @(posedge clock) begin : item_driver
      logic fire;
      logic send;
      int   gap_pct;
      fire = req_valid && !req_stall;
      if (reset) begin
         for (int i = 0; i < 32; i++) cpu_mem[i] = 8'h00;
         cpu_mem[INPUT_CELL] = NEWLINE_CHAR;
         cpu_acc = 8'h00;
         cpu_pc = 8'h00;
      end else begin
         if (fire) begin
            expected_reports.push_back(execute_item(active_item));
            n_items++;
            if (active_item.cmd == CMD_RUN) n_runs++;
         end
         idle_phase <= (n_items < total_items / 3) ? 0 : (n_items < 2 * total_items / 3) ? 1 : 2;
         gap_pct = (idle_phase == 0) ? 7 : (idle_phase == 1) ? 86 : 0;
         if (!req_valid || fire) begin
            send = (pending_items.size() > 0) && ($urandom_range(0, 99) >= gap_pct);
            if (send && pending_items[0].drain_first && expected_reports.size() != 0)
               send = 1'b0;
            if (send) begin
               active_item = pending_items.pop_front();
               req_cmd <= active_item.cmd;
               req_load_addr <= active_item.load_addr;
               req_load_word <= active_item.load_word;
               req_in_char <= active_item.in_char;
            end
            req_valid <= send;
         end
      end
   end

   always @(posedge clock) begin : report_monitor
      cycle_report_t want;
      int            stall_pct;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_reports.size() == 0) begin
               $display("%0t: report with no pending item, pc 0x%02h acc 0x%02h",
                        $time, rsp_pc_now, rsp_acc_now);
               n_errors++;
            end else begin
               want = expected_reports.pop_front();
               check_field("out_valid", 8'(want.out_valid), 8'(rsp_out_valid));
               check_field("out_char", want.out_char, rsp_out_char);
               check_field("in_taken", 8'(want.in_taken), 8'(rsp_in_taken));
               check_field("pc_now", want.pc_now, rsp_pc_now);
               check_field("acc_now", want.acc_now, rsp_acc_now);
               n_checked++;
               if (want.out_valid) n_emitted++;
               if (want.in_taken) n_taken++;
            end
         end
         stall_pct = (idle_phase == 0) ? 86 : (idle_phase == 1) ? 7 : 0;
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   always @(posedge clock) begin : hang_watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
         if (stuck_cycles >= HANG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, HANG_LIMIT);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin : run_control
      logic [4:0] addr;
      logic [7:0] word;
      logic [2:0] op_bits;

      // A short program that walks through every opcode, both I/O cells and a branch wrap.
      queue_item(CMD_LOAD, 5'd31, 8'hFF, 8'h00);
      queue_item(CMD_LOAD, 5'd29, 8'h80, 8'hFF);
      queue_item(CMD_LOAD, 5'd27, 8'h00, 8'h55);
      queue_item(CMD_LOAD, 5'd0,  {OP_LOAD,  INPUT_CELL}, 8'hFF);
      queue_item(CMD_LOAD, 5'd1,  {OP_STORE, OUTPUT_CELL}, 8'h00);
      queue_item(CMD_LOAD, 5'd2,  {OP_SUB,   5'd29}, 8'hFF);
      queue_item(CMD_LOAD, 5'd3,  {OP_JNEG,  5'd5}, 8'h00);
      queue_item(CMD_LOAD, 5'd5,  {OP_JPOS,  5'd0}, 8'hFF);
      queue_item(CMD_LOAD, 5'd6,  {OP_LOAD,  5'd27}, 8'h00);
      queue_item(CMD_LOAD, 5'd7,  {OP_STORE, INPUT_CELL}, 8'hFF);
      queue_item(CMD_LOAD, 5'd8,  {OP_JZERO, 5'd10}, 8'h00);
      queue_item(CMD_LOAD, 5'd10, {OP_ADD,   INPUT_CELL}, 8'hFF);
      queue_item(CMD_LOAD, 5'd11, {OP_JPOS,  5'd13}, 8'h00);
      queue_item(CMD_LOAD, 5'd13, {OP_JMP,   5'd0}, 8'hFF);
      queue_item(CMD_RUN, 5'd31, 8'hFF, 8'h00);
      queue_item(CMD_RUN, 5'd0,  8'h00, 8'hFF);
      queue_item(CMD_RUN, 5'd31, 8'hFF, 8'h00);
      queue_item(CMD_RUN, 5'd0,  8'h00, 8'hFF);
      queue_item(CMD_RUN, 5'd31, 8'hFF, 8'h00);
      queue_item(CMD_RUN, 5'd0,  8'h00, 8'hFF);
      queue_item(CMD_RUN, 5'd31, 8'hFF, 8'h00);
      queue_item(CMD_RUN, 5'd0,  8'h00, 8'h7F);
      queue_item(CMD_RUN, 5'd31, 8'hFF, 8'h00);
      queue_item(CMD_RUN, 5'd0,  8'h00, 8'hFF);
      queue_item(CMD_RUN, 5'd31, 8'hFF, 8'h00);

      // The sender holds this item back until every earlier report has arrived.
      queue_item(CMD_RUN, 5'd0, 8'h00, 8'h41, 1'b1);

      while (pending_items.size() < TOTAL_ITEMS) begin
         if ($urandom_range(0, 9) < 7) begin
            repeat ($urandom_range(2, 8)) begin
               addr = 5'($urandom_range(0, 31));
               case ($urandom_range(0, 3))
                  0: begin
                     op_bits = 3'($urandom_range(0, 7));
                     word = {op_bits, ($urandom_range(0, 1) ? INPUT_CELL : OUTPUT_CELL)};
                  end
                  1: begin
                     addr = INPUT_CELL;
                     word = 8'h00;
                  end
                  default: word = 8'($urandom_range(0, 255));
               endcase
               queue_item(CMD_LOAD, addr, word, 8'($urandom_range(0, 255)));
            end
            repeat ($urandom_range(4, 24))
               queue_item(CMD_RUN, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)));
         end else begin
            repeat ($urandom_range(3, 12))
               queue_item(cmd_type'(1'($urandom_range(0, 1))), 5'($urandom_range(0, 31)),
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         end
      end
      total_items = pending_items.size();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (pending_items.size() != 0 || req_valid || expected_reports.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Checked %0d reports for %0d items, %0d of them machine cycles,",
               n_checked, n_items, n_runs);
      $display("over three idle profiles; %0d characters out, %0d in, %0d mismatches seen.",
               n_emitted, n_taken, n_errors);
      if (n_errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
